[hw/rtl/mqpq_pkg.sv]
`default_nettype none

package mqpq_pkg;

  localparam int ID_W      = 31;
  localparam int PRIO_W    = 3;
  localparam int TIME_W    = 32;
  localparam int KEY_W     = PRIO_W + TIME_W;
  localparam int TAG_W     = 32;
  localparam int CNT_OUT_W = 5;
  localparam int ENTRY_W   = ID_W + KEY_W + TAG_W;

  typedef enum logic [2:0] {
    ST_INSERTED    = 3'd0,
    ST_DUPLICATE   = 3'd1,
    ST_NOT_WAITING = 3'd2,
    ST_FULL        = 3'd3,
    ST_POPPED      = 3'd4,
    ST_EMPTY       = 3'd5,
    ST_COUNT       = 3'd6
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;        // capture the request
    logic    scan;        // duplicate / position scan step
    logic    shift_init;  // point at the tail before moving entries
    logic    shift;       // move one entry up by one place
    logic    ins_wr;      // write the new entry, count + 1
    logic    pop_take;    // take the front entry, count - 1
    logic    res_en;      // load the result registers
    status_t res_code;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_insert;
    logic is_pop;
    logic waiting;
    logic empty;
    logic full;
    logic scan_last;
    logic dup;
    logic pos_at_end;
    logic shift_last;
  } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/multi_queue_priority_ordered_queue.sv]
// From the start transfer to the result strobe (n = entries in the queue, p = insert
//   position): count, not-waiting or empty pop end at the check; pop then takes the
//   front; dup or full end after scanning n entries; insert moves n-p entries up.
// Throughput: one operation at a time; busy is low again in the strobe cycle.
// Reset (rst_n low, synchronous) empties every queue; entry storage is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
`default_nettype none

module multi_queue_priority_ordered_queue #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // request channel: transfer when start && !busy
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [2:0]  in_queue_index,
  input  wire logic [30:0] in_visit_id,
  input  wire logic [2:0]  in_priority_req,
  input  wire logic [31:0] in_reg_time,
  input  wire logic [31:0] in_payload_tag,
  input  wire logic        in_is_waiting,

  // result channel: one-cycle strobe
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [30:0]      out_visit_id,
  output logic [2:0]       out_priority,
  output logic [31:0]      out_reg_time,
  output logic [31:0]      out_payload_tag,
  output logic [4:0]       out_queue_count
);
  import mqpq_pkg::*;

  // Each queue is a ring in one shared store: a head pointer and a count
  // per queue, entries kept sorted by {priority, reg_time}.
  //
  // Insert: scan the queue one entry per cycle through the store's read
  // port, flagging a matching visit id and counting entries whose key is
  // <= the new key (that count is the stable insert position). If accepted,
  // the tail down to that position moves up one slot, one entry per cycle
  // (read k, write k+1 the cycle after), then the new entry is written.
  //
  // Pop: the front slot is read during the check cycle; the next cycle
  // returns it and advances the head, so nothing moves.
  //
  // The store's single read and single write port set the per-entry rate.

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mqpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  mqpq_dp #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_queue_index  (in_queue_index),
    .in_visit_id     (in_visit_id),
    .in_priority_req (in_priority_req),
    .in_reg_time     (in_reg_time),
    .in_payload_tag  (in_payload_tag),
    .in_is_waiting   (in_is_waiting),
    .out_status      (out_status),
    .out_visit_id    (out_visit_id),
    .out_priority    (out_priority),
    .out_reg_time    (out_reg_time),
    .out_payload_tag (out_payload_tag),
    .out_queue_count (out_queue_count)
  );

endmodule

`default_nettype wire

[hw/rtl/mqpq_ram.sv]
`default_nettype none

module mqpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/mqpq_ctrl.sv]
`default_nettype none

module mqpq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output logic                    out_valid,
  output mqpq_pkg::dp_cmd_t       cmd,
  input  wire mqpq_pkg::dp_stat_t stat
);
  import mqpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_SHIFT_WR,
    S_INS_WR,
    S_POP_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.res_code = ST_COUNT;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_insert) begin
          if (!stat.waiting) begin
            cmd.res_en   = 1'b1;
            cmd.res_code = ST_NOT_WAITING;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (stat.is_pop) begin
          if (stat.empty) begin
            cmd.res_en   = 1'b1;
            cmd.res_code = ST_EMPTY;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_POP_DONE;
          end
        end else begin
          cmd.res_en   = 1'b1;
          cmd.res_code = ST_COUNT;
          state_nxt    = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.dup) begin
          cmd.res_en   = 1'b1;
          cmd.res_code = ST_DUPLICATE;
          state_nxt    = S_IDLE;
        end else if (stat.full) begin
          cmd.res_en   = 1'b1;
          cmd.res_code = ST_FULL;
          state_nxt    = S_IDLE;
        end else if (stat.pos_at_end) begin
          state_nxt = S_INS_WR;
        end else begin
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.shift_last) begin
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.ins_wr   = 1'b1;
        cmd.res_en   = 1'b1;
        cmd.res_code = ST_INSERTED;
        state_nxt    = S_IDLE;
      end
      S_POP_DONE: begin
        cmd.pop_take = 1'b1;
        cmd.res_en   = 1'b1;
        cmd.res_code = ST_POPPED;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.res_en;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe outside idle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer accepted but controller stayed idle");

  a_result_ends_op: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_en |=> (state_r == S_IDLE) && out_valid_r)
    else $error("result issued without returning to idle");

endmodule

`default_nettype wire

[hw/rtl/mqpq_dp.sv]
`default_nettype none

module mqpq_dp #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mqpq_pkg::dp_cmd_t cmd,
  output mqpq_pkg::dp_stat_t     stat,
  input  wire logic [1:0]        in_action,
  input  wire logic [2:0]        in_queue_index,
  input  wire logic [30:0]       in_visit_id,
  input  wire logic [2:0]        in_priority_req,
  input  wire logic [31:0]       in_reg_time,
  input  wire logic [31:0]       in_payload_tag,
  input  wire logic              in_is_waiting,
  output logic [2:0]             out_status,
  output logic [30:0]            out_visit_id,
  output logic [2:0]             out_priority,
  output logic [31:0]            out_reg_time,
  output logic [31:0]            out_payload_tag,
  output logic [4:0]             out_queue_count
);
  import mqpq_pkg::*;

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int HW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SW    = CW + 1;
  localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW    = $clog2(SLOTS);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;

  // request
  logic [1:0]       act_r;
  logic [QW-1:0]    q_r;
  logic [ID_W-1:0]  id_r;
  logic [KEY_W-1:0] key_r;
  logic [TAG_W-1:0] tag_r;
  logic             wait_r;
  logic [CW-1:0]    n_r;
  logic [HW-1:0]    h_r;

  // scan / shift bookkeeping
  logic [CW-1:0]    idx_r;
  logic [CW-1:0]    pos_r;
  logic [CW-1:0]    wdst_r;
  logic             dup_r;
  logic             chk_r;
  logic             wpend_r;

  // per-queue ring state
  logic [CW-1:0]    cnt_r  [NUM_QUEUES];
  logic [HW-1:0]    head_r [NUM_QUEUES];

  // result
  status_t          res_status_r;
  logic [ID_W-1:0]  res_id_r;
  logic [KEY_W-1:0] res_key_r;
  logic [TAG_W-1:0] res_tag_r;
  logic [CNT_OUT_W-1:0] res_cnt_r;

  logic [6:0]       q_wrap;
  logic [QW-1:0]    q_in;
  logic [CW-1:0]    cnt_after;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ID_W-1:0]  rd_id;
  logic [KEY_W-1:0] rd_key;
  logic [TAG_W-1:0] rd_tag;

  // logical position in a queue -> slot in the shared store
  function automatic logic [AW-1:0] slot_addr(input logic [QW-1:0] q,
                                              input logic [HW-1:0] h,
                                              input logic [CW-1:0] l);
    logic [SW-1:0] s;
    logic [SW-1:0] w;
    s = SW'(h) + SW'(l);
    w = (s >= SW'(QUEUE_DEPTH)) ? (s - SW'(QUEUE_DEPTH)) : s;
    return AW'(q) * AW'(QUEUE_DEPTH) + AW'(w);
  endfunction

  // index modulo queue count, small operand
  always_comb begin
    q_wrap = {4'b0, in_queue_index};
    for (int k = 0; k < 7; k++) begin
      if (q_wrap >= 7'(NUM_QUEUES)) begin
        q_wrap = q_wrap - 7'(NUM_QUEUES);
      end
    end
  end
  assign q_in = QW'(q_wrap);

  assign rd_id  = ram_rdata[ENTRY_W-1 -: ID_W];
  assign rd_key = ram_rdata[KEY_W+TAG_W-1 -: KEY_W];
  assign rd_tag = ram_rdata[TAG_W-1:0];

  assign ram_raddr = slot_addr(q_r, h_r, idx_r);
  assign ram_waddr = slot_addr(q_r, h_r, wpend_r ? wdst_r : pos_r);
  assign ram_we    = wpend_r | cmd.ins_wr;
  assign ram_wdata = wpend_r ? ram_rdata : {id_r, key_r, tag_r};

  mqpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (cmd.ins_wr) begin
      cnt_after = n_r + CW'(1);
    end else if (cmd.pop_take) begin
      cnt_after = n_r - CW'(1);
    end else begin
      cnt_after = n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        cnt_r[i]  <= '0;
        head_r[i] <= '0;
      end
      chk_r   <= 1'b0;
      wpend_r <= 1'b0;
    end else begin
      chk_r   <= cmd.scan && (idx_r != n_r);
      wpend_r <= cmd.shift;
      if (cmd.ins_wr) begin
        cnt_r[q_r] <= cnt_after;
      end
      if (cmd.pop_take) begin
        cnt_r[q_r]  <= cnt_after;
        head_r[q_r] <= (h_r == HW'(QUEUE_DEPTH - 1)) ? '0 : h_r + HW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      q_r    <= q_in;
      id_r   <= in_visit_id;
      key_r  <= {in_priority_req, in_reg_time};
      tag_r  <= in_payload_tag;
      wait_r <= in_is_waiting;
      n_r    <= cnt_r[q_in];
      h_r    <= head_r[q_in];
      idx_r  <= '0;
      pos_r  <= '0;
      dup_r  <= 1'b0;
    end
    if (cmd.scan && (idx_r != n_r)) begin
      idx_r <= idx_r + CW'(1);
    end
    if (chk_r) begin
      if (rd_id == id_r) begin
        dup_r <= 1'b1;
      end
      if (rd_key <= key_r) begin
        pos_r <= pos_r + CW'(1);
      end
    end
    if (cmd.shift_init) begin
      idx_r <= n_r - CW'(1);
    end
    if (cmd.shift) begin
      wdst_r <= idx_r + CW'(1);
      idx_r  <= idx_r - CW'(1);
    end
    if (cmd.res_en) begin
      res_status_r <= cmd.res_code;
      res_cnt_r    <= CNT_OUT_W'(cnt_after);
      if (cmd.pop_take) begin
        res_id_r  <= rd_id;
        res_key_r <= rd_key;
        res_tag_r <= rd_tag;
      end else begin
        res_id_r  <= '0;
        res_key_r <= '0;
        res_tag_r <= '0;
      end
    end
  end

  assign stat.is_insert  = (act_r == ACT_INSERT);
  assign stat.is_pop     = (act_r == ACT_POP);
  assign stat.waiting    = wait_r;
  assign stat.empty      = (n_r == '0);
  assign stat.full       = (n_r == CW'(QUEUE_DEPTH));
  assign stat.scan_last  = (idx_r == n_r);
  assign stat.dup        = dup_r;
  assign stat.pos_at_end = (pos_r == n_r);
  assign stat.shift_last = (idx_r == pos_r);

  assign out_status      = res_status_r;
  assign out_visit_id    = res_id_r;
  assign out_priority    = res_key_r[KEY_W-1 -: PRIO_W];
  assign out_reg_time    = res_key_r[TIME_W-1:0];
  assign out_payload_tag = res_tag_r;
  assign out_queue_count = res_cnt_r;

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(wpend_r && cmd.ins_wr))
    else $error("shift write and insert write in the same cycle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_take |-> (n_r != '0))
    else $error("pop taken from an empty queue");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr |-> (n_r < CW'(QUEUE_DEPTH)) && !dup_r)
    else $error("insert into a full queue or over a duplicate");

endmodule

`default_nettype wire

[test/mqpq_checker.sv]
`timescale 1ns / 100ps

package mqpq_tb_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_COUNT  = 2'd2,
    OP_SPARE  = 2'd3   // unused code, answered like a count request
  } op_code_t;

endpackage

module mqpq_checker
  import mqpq_pkg::*;
  import mqpq_tb_pkg::*;
#(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_action,
  input  logic [2:0]        in_queue_index,
  input  logic [ID_W-1:0]   in_visit_id,
  input  logic [PRIO_W-1:0] in_priority_req,
  input  logic [TIME_W-1:0] in_reg_time,
  input  logic [TAG_W-1:0]  in_payload_tag,
  input  logic              in_is_waiting,
  input  logic              out_valid,
  input  logic [2:0]        out_status,
  input  logic [ID_W-1:0]   out_visit_id,
  input  logic [PRIO_W-1:0] out_priority,
  input  logic [TIME_W-1:0] out_reg_time,
  input  logic [TAG_W-1:0]  out_payload_tag,
  input  logic [4:0]        out_queue_count,
  output int                err_count,
  output int                in_flight
);

  typedef struct packed {
    status_t              status;
    logic [ID_W-1:0]      visit_id;
    logic [PRIO_W-1:0]    prio;
    logic [TIME_W-1:0]    reg_time;
    logic [TAG_W-1:0]     tag;
    logic [CNT_OUT_W-1:0] count;
  } outcome_t;

  // shadow copy of the sorted queues
  logic [ID_W-1:0]  slot_id  [NUM_QUEUES][QUEUE_DEPTH];
  logic [KEY_W-1:0] slot_key [NUM_QUEUES][QUEUE_DEPTH];
  logic [TAG_W-1:0] slot_tag [NUM_QUEUES][QUEUE_DEPTH];
  int               fill     [NUM_QUEUES];

  outcome_t expected_results [$];
  int       fails = 0;

  function automatic outcome_t serve_request(logic [1:0] op, logic [2:0] qi,
                                             logic [ID_W-1:0] id,
                                             logic [PRIO_W-1:0] pr,
                                             logic [TIME_W-1:0] tm,
                                             logic [TAG_W-1:0] tg,
                                             logic waiting);
    outcome_t         o;
    int               q;
    int               n;
    int               pos;
    int               i;
    bit               dup;
    logic [KEY_W-1:0] key;
    q   = qi % NUM_QUEUES;
    n   = fill[q];
    key = {pr, tm};
    dup = 1'b0;
    o.status   = ST_COUNT;
    o.visit_id = '0;
    o.prio     = '0;
    o.reg_time = '0;
    o.tag      = '0;
    o.count    = CNT_OUT_W'(n);
    case (op_code_t'(op))
      OP_INSERT: begin
        for (i = 0; i < n; i++)
          if (slot_id[q][i] == id) dup = 1'b1;
        if (!waiting) o.status = ST_NOT_WAITING;
        else if (dup) o.status = ST_DUPLICATE;
        else if (n >= QUEUE_DEPTH) o.status = ST_FULL;
        else begin
          // equal keys stay ahead of the new entry: ties leave in arrival order
          pos = n;
          while (pos > 0 && slot_key[q][pos-1] > key) begin
            slot_id[q][pos]  = slot_id[q][pos-1];
            slot_key[q][pos] = slot_key[q][pos-1];
            slot_tag[q][pos] = slot_tag[q][pos-1];
            pos--;
          end
          slot_id[q][pos]  = id;
          slot_key[q][pos] = key;
          slot_tag[q][pos] = tg;
          fill[q]  = n + 1;
          o.status = ST_INSERTED;
          o.count  = CNT_OUT_W'(n + 1);
        end
      end
      OP_POP: begin
        if (n == 0) o.status = ST_EMPTY;
        else begin
          o.status   = ST_POPPED;
          o.visit_id = slot_id[q][0];
          o.prio     = slot_key[q][0][KEY_W-1:TIME_W];
          o.reg_time = slot_key[q][0][TIME_W-1:0];
          o.tag      = slot_tag[q][0];
          for (i = 0; i + 1 < n; i++) begin
            slot_id[q][i]  = slot_id[q][i+1];
            slot_key[q][i] = slot_key[q][i+1];
            slot_tag[q][i] = slot_tag[q][i+1];
          end
          fill[q] = n - 1;
          o.count = CNT_OUT_W'(n - 1);
        end
      end
      default: o.status = ST_COUNT;
    endcase
    return o;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t e;
    if (!rst_n) begin
      for (int q = 0; q < NUM_QUEUES; q++) fill[q] = 0;
      expected_results.delete();
    end else begin
      // retire the result first: a new request can transfer on the same edge
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d, count %0d", out_status, out_queue_count);
          fails++;
        end else begin
          e = expected_results.pop_front();
          check_field("status", 32'(e.status), 32'(out_status));
          check_field("visit_id", 32'(e.visit_id), 32'(out_visit_id));
          check_field("priority", 32'(e.prio), 32'(out_priority));
          check_field("reg_time", e.reg_time, out_reg_time);
          check_field("payload_tag", e.tag, out_payload_tag);
          check_field("queue_count", 32'(e.count), 32'(out_queue_count));
        end
      end
      if (start && !busy)
        expected_results.push_back(serve_request(in_action, in_queue_index, in_visit_id,
                                                 in_priority_req, in_reg_time,
                                                 in_payload_tag, in_is_waiting));
    end
    err_count <= fails;
    in_flight <= expected_results.size();
  end

endmodule

[test/tb_multi_queue_priority_ordered_queue.sv]
`timescale 1ns / 100ps

module tb_multi_queue_priority_ordered_queue;
  import mqpq_pkg::*;
  import mqpq_tb_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_action;
  logic [2:0]  in_queue_index;
  logic [30:0] in_visit_id;
  logic [2:0]  in_priority_req;
  logic [31:0] in_reg_time;
  logic [31:0] in_payload_tag;
  logic        in_is_waiting;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [30:0] out_visit_id;
  logic [2:0]  out_priority;
  logic [31:0] out_reg_time;
  logic [31:0] out_payload_tag;
  logic [4:0]  out_queue_count;

  int err_count;
  int in_flight;   // results still owed by the block
  int idle_pct;    // chance, in percent, of a sender gap before each request

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  multi_queue_priority_ordered_queue u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_queue_index  (in_queue_index),
    .in_visit_id     (in_visit_id),
    .in_priority_req (in_priority_req),
    .in_reg_time     (in_reg_time),
    .in_payload_tag  (in_payload_tag),
    .in_is_waiting   (in_is_waiting),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_visit_id    (out_visit_id),
    .out_priority    (out_priority),
    .out_reg_time    (out_reg_time),
    .out_payload_tag (out_payload_tag),
    .out_queue_count (out_queue_count)
  );

  // Scoreboard sits beside the block: sees both channels, predicts, compares.
  mqpq_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_queue_index  (in_queue_index),
    .in_visit_id     (in_visit_id),
    .in_priority_req (in_priority_req),
    .in_reg_time     (in_reg_time),
    .in_payload_tag  (in_payload_tag),
    .in_is_waiting   (in_is_waiting),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_visit_id    (out_visit_id),
    .out_priority    (out_priority),
    .out_reg_time    (out_reg_time),
    .out_payload_tag (out_payload_tag),
    .out_queue_count (out_queue_count),
    .err_count       (err_count),
    .in_flight       (in_flight)
  );

  // About 400 requests with sender gaps finish long before 2 ms, so the
  // timeout leaves a wide margin.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // One request transfer. Called at a rising edge. start only drops when a
  // gap is taken, so it is never lowered and raised within the same step;
  // back-to-back requests simply keep it high.
  task automatic issue(op_code_t op, logic [2:0] qi, logic [30:0] id, logic [2:0] pr,
                       logic [31:0] tm, logic [31:0] tg, logic w);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start           <= 1'b1;
    in_action       <= op;
    in_queue_index  <= qi;
    in_visit_id     <= id;
    in_priority_req <= pr;
    in_reg_time     <= tm;
    in_payload_tag  <= tg;
    in_is_waiting   <= w;
    // busy is read before the edge's updates land, so this is the transfer edge
    do @(posedge clk); while (busy);
  endtask

  initial begin
    logic [30:0] id;
    logic [2:0]  pr;
    logic [31:0] tm;
    logic [31:0] tg;
    logic [2:0]  qi;
    logic        w;
    op_code_t    op;
    int          r;
    int          counted;
    int          sent;
    bit          fill_heavy;
    logic [2:0]  hot_q;

    start           <= 1'b0;
    in_action       <= OP_COUNT;
    in_queue_index  <= '0;
    in_visit_id     <= '0;
    in_priority_req <= '0;
    in_reg_time     <= '0;
    in_payload_tag  <= '0;
    in_is_waiting   <= 1'b0;
    rst_n           <= 1'b0;
    idle_pct = 37;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // count on an empty queue, spare action code on the top index, empty pop
    issue(OP_COUNT, 3'd0, '0, '0, '0, '0, 1'b1);
    issue(OP_SPARE, 3'd7, '1, '1, '1, '1, 1'b1);
    issue(OP_POP,   3'd3, '0, '0, '0, '0, 1'b0);

    // fill queue 0 to the brim with falling priorities so every insert after
    // the second shifts; field extremes on the first and last, equal keys at the end
    for (int k = 0; k < 16; k++) begin
      id = (k == 0) ? 31'd0 : (k == 15) ? 31'h7FFF_FFFF : 31'(k + 100);
      pr = 3'(7 - k / 2);
      tm = (k >= 14) ? 32'd0 : (k % 3 == 0) ? 32'd0 : (k % 3 == 1) ? 32'hFFFF_FFFF : 32'd1000;
      tg = (k == 0) ? 32'd0 : (k == 15) ? 32'hFFFF_FFFF : $urandom;
      issue(OP_INSERT, 3'd0, id, pr, tm, tg, 1'b1);
    end
    issue(OP_INSERT, 3'd0, 31'd4242, 3'd0, 32'd0, 32'd0, 1'b1);        // full
    issue(OP_INSERT, 3'd0, 31'h7FFF_FFFF, 3'd1, 32'd9, 32'd9, 1'b1);   // duplicate wins over full
    issue(OP_INSERT, 3'd0, 31'd4243, 3'd1, 32'd9, 32'd9, 1'b0);        // not waiting wins over full
    repeat (3) issue(OP_POP, 3'd0, '0, '0, '0, '0, 1'b0);              // the two tied keys first

    // --- random ---
    // Traffic is focused on one hot queue that changes every 40 requests,
    // alternating between insert-heavy (drives it toward full) and pop-heavy
    // (drains it toward empty). A small id pool makes duplicates common and a
    // narrow time range makes equal keys common.
    sent       = 0;
    fill_heavy = 1'b1;
    hot_q      = 3'($urandom_range(7));
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 37 : (ph == 1) ? 68 : 0;
      counted  = 0;
      while (counted < 125) begin
        if (sent % 40 == 39) begin
          hot_q      = 3'($urandom_range(7));
          fill_heavy = !fill_heavy;
        end
        r  = $urandom_range(99);
        qi = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : hot_q;
        if (r < (fill_heavy ? 70 : 25)) op = OP_INSERT;
        else if (r < (fill_heavy ? 90 : 85)) op = OP_POP;
        else op = $urandom_range(1) ? OP_COUNT : OP_SPARE;
        id = $urandom_range(1) ? 31'($urandom_range(23)) : 31'($urandom);
        pr = 3'($urandom_range(7));
        tm = $urandom_range(1) ? 32'($urandom_range(3)) : $urandom;
        tg = $urandom;
        w  = ($urandom_range(99) >= 8);
        issue(op, qi, id, pr, tm, tg, w);
        sent++;
        counted++;
      end
    end
    start <= 1'b0;

    // drain: in_flight is registered and lags the checker's queue, then allow for a stray strobe
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[multi_queue_priority_ordered_queue.f]
hw/rtl/mqpq_pkg.sv
hw/rtl/mqpq_ram.sv
hw/rtl/mqpq_ctrl.sv
hw/rtl/mqpq_dp.sv
hw/rtl/multi_queue_priority_ordered_queue.sv
test/mqpq_checker.sv
test/tb_multi_queue_priority_ordered_queue.sv
